>>> hdl/pqfc_pkg.sv
// ----------------------------------------------------------------------------
// pqfc_pkg: shared types and constants for the presence qualified fan control
// Word layouts, configuration register map and reset values.
// ----------------------------------------------------------------------------
package pqfc_pkg;

  // Timestamp width default and the fixed input timestamp width
  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Long absence delay is kept in milliseconds: 16 bit seconds times 1000
  localparam int MS_PER_S   = 1000;
  localparam int DELAY_MS_W = 26;

  // Queue depths
  localparam int JOB_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_ENABLE      = 3'd0,
    CFG_TEMP_ON_TENTHS   = 3'd1,
    CFG_SPEED_MIN        = 3'd2,
    CFG_SPEED_MAX        = 3'd3,
    CFG_ABSENCE_DELAY_S  = 3'd4,
    CFG_MIN_DISTANCE_CM  = 3'd5,
    CFG_PRESENCE_HOLD_MS = 3'd6,
    CFG_ABSENCE_HOLD_MS  = 3'd7
  } cfg_idx_e;

  // Reset values
  localparam logic               RST_AUTO_ENABLE      = 1'b0;
  localparam logic signed [11:0] RST_TEMP_ON_TENTHS   = 12'sd250;
  localparam logic [7:0]         RST_SPEED_MIN        = 8'd30;
  localparam logic [7:0]         RST_SPEED_MAX        = 8'd100;
  localparam logic [15:0]        RST_ABSENCE_DELAY_S  = 16'd30;
  localparam logic [9:0]         RST_MIN_DISTANCE_CM  = 10'd20;
  localparam logic [15:0]        RST_PRESENCE_HOLD_MS = 16'd1000;
  localparam logic [15:0]        RST_ABSENCE_HOLD_MS  = 16'd2000;

  // Input word: one radar report
  typedef struct packed {
    logic               sensor_connected;
    logic               presence_flag;
    logic               moving_flag;
    logic [9:0]         moving_distance;
    logic               stationary_flag;
    logic [9:0]         stationary_distance;
    logic [NOW_W-1:0]   now_ms;
    logic signed [11:0] temperature_tenths;
    logic               fan_is_running;
    logic [7:0]         fan_speed_now;
  } in_word_t;

  // Output word: one result
  typedef struct packed {
    logic       presence_detected;
    logic [9:0] distance_cm;
    logic       presence_changed;
    logic       fan_on_cmd;
    logic       fan_off_cmd;
    logic       speed_write;
    logic [7:0] speed_value;
  } out_word_t;

  // Configuration register set
  typedef struct packed {
    logic                  auto_enable;
    logic signed [11:0]    temp_on_tenths;
    logic [7:0]            speed_min;
    logic [7:0]            speed_max;
    logic [DELAY_MS_W-1:0] absence_delay_ms;
    logic [9:0]            min_distance_cm;
    logic [15:0]           presence_hold_ms;
    logic [15:0]           absence_hold_ms;
  } cfg_t;

  // Classified report, front to back
  typedef struct packed {
    logic             connected;
    logic             presence;
    logic             target;      // moving or stationary target flagged
    logic [9:0]       distance;    // distance of the flagged target
    logic             dist_ok;     // target flagged and beyond min distance
    logic [NOW_W-1:0] now_ms;
    logic             warm;        // temperature above threshold
    logic             running;
    logic             speed_diff;  // clamped speed differs from applied speed
    logic [7:0]       speed;       // clamped automatic speed
  } job_t;

endpackage

>>> hdl/pqfc_fifo.sv
// ----------------------------------------------------------------------------
// pqfc_fifo: small synchronous queue
// Register based circular queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module pqfc_fifo #(
  parameter type T     = logic,
  parameter int  Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Word storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/pqfc_cfg.sv
// ----------------------------------------------------------------------------
// pqfc_cfg: configuration registers
// Register file written over the config channel; flags auto mode turn-off.
// ----------------------------------------------------------------------------
module pqfc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pqfc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pqfc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output pqfc_pkg::cfg_t                      cfg_o,
  output logic                                auto_clr_o
);

  import pqfc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_idx_e idx;
  logic     wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;
  assign idx         = cfg_idx_e'(cfg_index_i);
  assign cfg_o       = cfg_q;

  // Turning auto mode off drops was-present and the absence timer
  assign auto_clr_o = wr && (idx == CFG_AUTO_ENABLE) && !cfg_data_i[0];

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        CFG_AUTO_ENABLE:      cfg_d.auto_enable      = cfg_data_i[0];
        CFG_TEMP_ON_TENTHS:   cfg_d.temp_on_tenths   = $signed(cfg_data_i[11:0]);
        CFG_SPEED_MIN:        cfg_d.speed_min        = cfg_data_i[7:0];
        CFG_SPEED_MAX:        cfg_d.speed_max        = cfg_data_i[7:0];
        CFG_ABSENCE_DELAY_S:  cfg_d.absence_delay_ms =
            DELAY_MS_W'(cfg_data_i[15:0]) * DELAY_MS_W'(MS_PER_S);
        CFG_MIN_DISTANCE_CM:  cfg_d.min_distance_cm  = cfg_data_i[9:0];
        CFG_PRESENCE_HOLD_MS: cfg_d.presence_hold_ms = cfg_data_i[15:0];
        CFG_ABSENCE_HOLD_MS:  cfg_d.absence_hold_ms  = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_enable      <= RST_AUTO_ENABLE;
      cfg_q.temp_on_tenths   <= RST_TEMP_ON_TENTHS;
      cfg_q.speed_min        <= RST_SPEED_MIN;
      cfg_q.speed_max        <= RST_SPEED_MAX;
      cfg_q.absence_delay_ms <= DELAY_MS_W'(RST_ABSENCE_DELAY_S) * DELAY_MS_W'(MS_PER_S);
      cfg_q.min_distance_cm  <= RST_MIN_DISTANCE_CM;
      cfg_q.presence_hold_ms <= RST_PRESENCE_HOLD_MS;
      cfg_q.absence_hold_ms  <= RST_ABSENCE_HOLD_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hdl/pqfc_front.sv
// ----------------------------------------------------------------------------
// pqfc_front: report classifier
// Picks the target distance, qualifies it and works out the automatic speed.
// ----------------------------------------------------------------------------
module pqfc_front (
  input  pqfc_pkg::in_word_t in_word_i,
  input  pqfc_pkg::cfg_t     cfg_i,
  output pqfc_pkg::job_t     job_o
);

  import pqfc_pkg::*;

  logic signed [12:0] temp_diff;
  logic [12:0]        spd_raw;
  logic [7:0]         spd_clamp;
  logic               target;
  logic [9:0]         tgt_dist;

  // Moving target wins over stationary
  assign target   = in_word_i.moving_flag || in_word_i.stationary_flag;
  assign tgt_dist = in_word_i.moving_flag ? in_word_i.moving_distance
                                          : in_word_i.stationary_distance;

  // Speed = min + excess/2, limited to max; only used when warm
  assign temp_diff = 13'(in_word_i.temperature_tenths) - 13'(cfg_i.temp_on_tenths);
  assign spd_raw   = 13'(cfg_i.speed_min) + 13'(temp_diff[12:1]);
  assign spd_clamp = (spd_raw > 13'(cfg_i.speed_max)) ? cfg_i.speed_max : spd_raw[7:0];

  always_comb begin
    job_o.connected  = in_word_i.sensor_connected;
    job_o.presence   = in_word_i.presence_flag;
    job_o.target     = target;
    job_o.distance   = tgt_dist;
    job_o.dist_ok    = target && (tgt_dist > cfg_i.min_distance_cm);
    job_o.now_ms     = in_word_i.now_ms;
    job_o.warm       = !temp_diff[12] && (temp_diff != '0);
    job_o.running    = in_word_i.fan_is_running;
    job_o.speed_diff = (spd_clamp != in_word_i.fan_speed_now);
    job_o.speed      = spd_clamp;
  end

endmodule

>>> hdl/pqfc_back.sv
// ----------------------------------------------------------------------------
// pqfc_back: presence qualifier and fan decision
// Holds presence/absence timers and state, issues one result per report.
// ----------------------------------------------------------------------------
module pqfc_back #(
  parameter int TimeBits = pqfc_pkg::TIME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pqfc_pkg::cfg_t      cfg_i,
  input  logic                auto_clr_i,
  input  logic                job_empty_i,
  input  pqfc_pkg::job_t      job_i,
  output logic                job_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output pqfc_pkg::out_word_t res_o
);

  import pqfc_pkg::*;

  localparam int CmpW = (TimeBits > DELAY_MS_W) ? TimeBits : DELAY_MS_W;

  logic                ps_q, ps_d;
  logic [9:0]          hd_q, hd_d;
  logic [TimeBits-1:0] pst_q, pst_d;
  logic                ptv_q, ptv_d;
  logic [TimeBits-1:0] ast_q, ast_d;
  logic                atv_q, atv_d;
  logic                wp_q, wp_d;
  logic [TimeBits-1:0] now_t;
  logic [TimeBits-1:0] p_since, a_since;
  logic                go;
  logic                f_start, f_stop, s_write;

  assign go         = !job_empty_i && !res_full_i;
  assign job_pop_o  = go;
  assign res_push_o = go;
  assign now_t      = TimeBits'(job_i.now_ms);

  // Per-report state update and fan decision
  always_comb begin
    ps_d    = ps_q;
    hd_d    = hd_q;
    pst_d   = pst_q;
    ptv_d   = ptv_q;
    ast_d   = ast_q;
    atv_d   = atv_q;
    wp_d    = wp_q;
    p_since = '0;
    a_since = '0;
    f_start = 1'b0;
    f_stop  = 1'b0;
    s_write = 1'b0;

    // presence qualification
    if (job_i.connected) begin
      if (job_i.presence) begin
        if (job_i.target) begin
          hd_d = job_i.distance;
        end
        if (job_i.dist_ok) begin
          if (!ptv_q) begin
            pst_d = now_t;
            ptv_d = 1'b1;
          end
          p_since = now_t - pst_d;
          if (p_since >= TimeBits'(cfg_i.presence_hold_ms)) begin
            ps_d = 1'b1;
          end
        end else begin
          ptv_d = 1'b0;
        end
        atv_d = 1'b0;
      end else begin
        ptv_d = 1'b0;
        hd_d  = '0;
        if (ps_q) begin
          if (!atv_q) begin
            ast_d = now_t;
            atv_d = 1'b1;
          end
          a_since = now_t - ast_d;
          if (a_since >= TimeBits'(cfg_i.absence_hold_ms)) begin
            ps_d = 1'b0;
          end
        end
      end
    end else begin
      ps_d = 1'b0;
      hd_d = '0;
    end

    // automatic fan mode
    if (cfg_i.auto_enable) begin
      if (ps_d) begin
        atv_d = 1'b0;
        wp_d  = 1'b1;
        if (job_i.warm) begin
          f_start = !job_i.running;
          s_write = job_i.speed_diff;
        end else if (job_i.running) begin
          f_stop = 1'b1;
        end
      end else if (wp_q) begin
        if (!atv_d) begin
          ast_d = now_t;
          atv_d = 1'b1;
        end
        a_since = now_t - ast_d;
        if ((CmpW'(a_since) >= CmpW'(cfg_i.absence_delay_ms)) && job_i.running) begin
          f_stop = 1'b1;
          wp_d   = 1'b0;
        end
      end
    end
  end

  // Result word
  always_comb begin
    res_o.presence_detected = ps_d;
    res_o.distance_cm       = hd_d;
    res_o.presence_changed  = (ps_d != ps_q);
    res_o.fan_on_cmd        = f_start;
    res_o.fan_off_cmd       = f_stop;
    res_o.speed_write       = s_write;
    res_o.speed_value       = s_write ? job_i.speed : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q  <= 1'b0;
      hd_q  <= '0;
      pst_q <= '0;
      ptv_q <= 1'b0;
      ast_q <= '0;
      atv_q <= 1'b0;
      wp_q  <= 1'b0;
    end else if (auto_clr_i) begin
      wp_q  <= 1'b0;
      atv_q <= 1'b0;
    end else if (go) begin
      ps_q  <= ps_d;
      hd_q  <= hd_d;
      pst_q <= pst_d;
      ptv_q <= ptv_d;
      ast_q <= ast_d;
      atv_q <= atv_d;
      wp_q  <= wp_d;
    end
  end

  // Start and stop never in one word
  a_start_stop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !(res_o.fan_on_cmd && res_o.fan_off_cmd))
    else $error("fan start and stop in one word");

  // Manual mode issues no fan commands
  a_manual_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && !cfg_i.auto_enable |->
      !res_o.fan_on_cmd && !res_o.fan_off_cmd && !res_o.speed_write)
    else $error("fan command outside auto mode");

  // Disconnected sensor reports absence at zero distance
  a_disconnect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && !job_i.connected |->
      !res_o.presence_detected && (res_o.distance_cm == '0))
    else $error("presence reported while disconnected");

  // Auto mode turn-off clears long absence tracking
  a_auto_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    auto_clr_i |=> !wp_q && !atv_q)
    else $error("was-present not cleared");

endmodule

>>> hdl/presence_qualified_fan_control_unit.sv
// ----------------------------------------------------------------------------
// presence_qualified_fan_control_unit: radar presence qualifier with fan control
// A report is registered in the job queue and again in the result queue; the
// back end stalls while the result queue is full. Throughput: one report per
// cycle unless stalled; its state update closes the loop on presence and timers.
// Reset: asynchronous, clears both queues, state, timers and loads config defaults.
// ----------------------------------------------------------------------------
module presence_qualified_fan_control_unit #(
  parameter int TimeBits = pqfc_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  input  pqfc_pkg::in_word_t              in_word_i,
  output logic                            full,
  input  logic                            pop,
  output pqfc_pkg::out_word_t             out_word_o,
  output logic                            empty,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pqfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pqfc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import pqfc_pkg::*;

  cfg_t      cfg;
  logic      auto_clr;
  job_t      job_in, job_out;
  logic      job_empty, job_pop;
  out_word_t res;
  logic      res_full, res_push;

  // Configuration registers
  pqfc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .auto_clr_o  (auto_clr)
  );

  // Front end: classify report
  pqfc_front u_front (
    .in_word_i (in_word_i),
    .cfg_i     (cfg),
    .job_o     (job_in)
  );

  // Queue between front and back
  pqfc_fifo #(
    .T     (job_t),
    .Depth (JOB_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // Back end: state and fan decision
  pqfc_back #(
    .TimeBits (TimeBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .auto_clr_i  (auto_clr),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue
  pqfc_fifo #(
    .T     (out_word_t),
    .Depth (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_word_o),
    .empty_o (empty)
  );

endmodule

>>> dv/pqfc_checker.sv
// ----------------------------------------------------------------------------
// pqfc_checker: result predictor and scoreboard for the fan control unit
// Watches the report, result and configuration channels, keeps its own copy of
// the qualifier state and settings, and compares every popped word in order.
// ----------------------------------------------------------------------------
module pqfc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            full_i,
  input  pqfc_pkg::in_word_t              in_word_i,
  input  logic                            pop_i,
  input  logic                            empty_i,
  input  pqfc_pkg::out_word_t             out_word_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [pqfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pqfc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              mismatches_o,
  output int                              outstanding_o,
  output int                              checked_o,
  output int                              presence_edges_o,
  output int                              fan_cmds_o
);

  import pqfc_pkg::*;

  // Settings as last written
  logic               auto_en;
  logic signed [11:0] temp_on;
  logic [7:0]         spd_min;
  logic [7:0]         spd_max;
  logic [15:0]        delay_s;
  logic [9:0]         min_dist;
  logic [15:0]        hold_on_ms;
  logic [15:0]        hold_off_ms;

  // Qualifier state
  logic               detected_q;
  logic [9:0]         dist_q;
  logic [31:0]        arm_start;   // start of the current run of valid reports
  logic               arm_tv;
  logic [31:0]        gone_start;  // start of the current absence
  logic               gone_tv;
  logic               seen_q;      // presence seen since the fan was last stopped

  out_word_t          pending_results[$];
  int                 errors;
  int                 checked;
  int                 edges;
  int                 cmds;

  // Expected word for one report; advances the qualifier state
  function automatic out_word_t qualify_report(input in_word_t w);
    out_word_t   r;
    logic        was_detected;
    logic [31:0] now;
    logic [31:0] elapsed;
    int          temp;
    int          thr;
    int          speed;
    r            = '0;
    was_detected = detected_q;
    now          = w.now_ms;
    temp         = $signed(w.temperature_tenths);
    thr          = temp_on;

    // Presence qualification
    if (w.sensor_connected) begin
      if (w.presence_flag) begin
        if (w.moving_flag) begin
          dist_q = w.moving_distance;
        end else if (w.stationary_flag) begin
          dist_q = w.stationary_distance;
        end
        if ((w.moving_flag || w.stationary_flag) && dist_q > min_dist) begin
          if (!arm_tv) begin
            arm_start = now;
            arm_tv    = 1'b1;
          end
          elapsed = now - arm_start;
          if (elapsed >= hold_on_ms) detected_q = 1'b1;
        end else begin
          arm_tv = 1'b0;
        end
        gone_tv = 1'b0;
      end else begin
        arm_tv = 1'b0;
        dist_q = '0;
        if (detected_q) begin
          if (!gone_tv) begin
            gone_start = now;
            gone_tv    = 1'b1;
          end
          elapsed = now - gone_start;
          if (elapsed >= hold_off_ms) detected_q = 1'b0;
        end
      end
    end else begin
      // link lost: drop presence at once, timers untouched
      detected_q = 1'b0;
      dist_q     = '0;
    end

    // Automatic fan commands
    if (auto_en) begin
      if (detected_q) begin
        gone_tv = 1'b0;
        seen_q  = 1'b1;
        if (temp > thr) begin
          if (!w.fan_is_running) r.fan_on_cmd = 1'b1;
          speed = int'(spd_min) + (temp - thr) / 2;
          if (speed < int'(spd_min)) begin
            speed = spd_min;
          end else if (speed > int'(spd_max)) begin
            speed = spd_max;
          end
          if (speed != int'(w.fan_speed_now)) begin
            r.speed_write = 1'b1;
            r.speed_value = 8'(speed);
          end
        end else if (w.fan_is_running) begin
          r.fan_off_cmd = 1'b1;
        end
      end else if (seen_q) begin
        if (!gone_tv) begin
          gone_start = now;
          gone_tv    = 1'b1;
        end
        elapsed = now - gone_start;
        // long absence stops only a running fan; otherwise retried
        if ((elapsed / 32'd1000) >= delay_s && w.fan_is_running) begin
          r.fan_off_cmd = 1'b1;
          seen_q        = 1'b0;
        end
      end
    end

    r.presence_detected = detected_q;
    r.distance_cm       = dist_q;
    r.presence_changed  = (detected_q != was_detected);
    return r;
  endfunction

  // Channel monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t want;
    logic      bad;
    if (!rst_ni) begin
      auto_en     = RST_AUTO_ENABLE;
      temp_on     = RST_TEMP_ON_TENTHS;
      spd_min     = RST_SPEED_MIN;
      spd_max     = RST_SPEED_MAX;
      delay_s     = RST_ABSENCE_DELAY_S;
      min_dist    = RST_MIN_DISTANCE_CM;
      hold_on_ms  = RST_PRESENCE_HOLD_MS;
      hold_off_ms = RST_ABSENCE_HOLD_MS;
      detected_q  = 1'b0;
      dist_q      = '0;
      arm_start   = '0;
      arm_tv      = 1'b0;
      gone_start  = '0;
      gone_tv     = 1'b0;
      seen_q      = 1'b0;
      pending_results.delete();
      errors      = 0;
      checked     = 0;
      edges       = 0;
      cmds        = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_AUTO_ENABLE: begin
            auto_en = cfg_data_i[0];
            if (!cfg_data_i[0]) begin
              seen_q  = 1'b0;
              gone_tv = 1'b0;
            end
          end
          CFG_TEMP_ON_TENTHS:   temp_on     = cfg_data_i[11:0];
          CFG_SPEED_MIN:        spd_min     = cfg_data_i[7:0];
          CFG_SPEED_MAX:        spd_max     = cfg_data_i[7:0];
          CFG_ABSENCE_DELAY_S:  delay_s     = cfg_data_i;
          CFG_MIN_DISTANCE_CM:  min_dist    = cfg_data_i[9:0];
          CFG_PRESENCE_HOLD_MS: hold_on_ms  = cfg_data_i;
          CFG_ABSENCE_HOLD_MS:  hold_off_ms = cfg_data_i;
          default: ;
        endcase
      end

      // accepted report
      if (push_i && !full_i) begin
        want = qualify_report(in_word_i);
        pending_results.push_back(want);
        edges = edges + int'(want.presence_changed);
        cmds  = cmds + int'(want.fan_on_cmd) + int'(want.fan_off_cmd);
      end

      // accepted result word
      if (pop_i && !empty_i) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: result word with nothing expected: %h", out_word_i);
        end else begin
          want = pending_results.pop_front();
          bad  = (out_word_i.presence_detected !== want.presence_detected)
              || (out_word_i.distance_cm       !== want.distance_cm)
              || (out_word_i.presence_changed  !== want.presence_changed)
              || (out_word_i.fan_on_cmd        !== want.fan_on_cmd)
              || (out_word_i.fan_off_cmd       !== want.fan_off_cmd)
              || (out_word_i.speed_write       !== want.speed_write)
              || (out_word_i.speed_value       !== want.speed_value);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("ERROR: word %0d exp det=%b dist=%0d chg=%b on=%b off=%b wr=%b spd=%0d",
                       checked, want.presence_detected, want.distance_cm,
                       want.presence_changed, want.fan_on_cmd, want.fan_off_cmd,
                       want.speed_write, want.speed_value);
              $display("       got det=%b dist=%0d chg=%b on=%b off=%b wr=%b spd=%0d",
                       out_word_i.presence_detected, out_word_i.distance_cm,
                       out_word_i.presence_changed, out_word_i.fan_on_cmd,
                       out_word_i.fan_off_cmd, out_word_i.speed_write,
                       out_word_i.speed_value);
            end
          end
          checked++;
        end
      end
    end
    mismatches_o     <= errors;
    outstanding_o    <= pending_results.size();
    checked_o        <= checked;
    presence_edges_o <= edges;
    fan_cmds_o       <= cmds;
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the presence qualified fan control unit
// Drives radar reports in bursts, stalls the result side on a changing
// pattern, rewrites the settings between phases and leaves checking to
// pqfc_checker. Directed reports first, then random presence episodes.
// ----------------------------------------------------------------------------
module testbench;
  import pqfc_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 12;
  localparam int PHASE_REPORTS   = 136;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum int {EP_PRESENT, EP_ABSENT, EP_NOISE} episode_e;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  push      = 1'b0;
  in_word_t              in_word   = '0;
  logic                  full;
  logic                  pop       = 1'b0;
  out_word_t             out_word;
  logic                  empty;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          mismatches;
  int          outstanding;
  int          checked;
  int          presence_edges;
  int          fan_cmds;
  int          cycle_count  = 0;
  int          reports_sent = 0;
  int          cfg_writes   = 0;
  logic        hold_off_req = 1'b0;

  // Copies of the settings used only to shape the stimulus
  int          cur_thr      = 250;
  int          cur_min_dist = 20;
  int          cur_smin     = 30;
  int          step_max     = 200;
  logic [31:0] clock_ms     = '0;
  logic        fan_on       = 1'b0;

  always #6 clk_i = ~clk_i;

  presence_qualified_fan_control_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_word_i   (in_word),
    .full        (full),
    .pop         (pop),
    .out_word_o  (out_word),
    .empty       (empty),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pqfc_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .in_word_i        (in_word),
    .pop_i            (pop),
    .empty_i          (empty),
    .out_word_i       (out_word),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding),
    .checked_o        (checked),
    .presence_edges_o (presence_edges),
    .fan_cmds_o       (fan_cmds)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected", cycle_count, outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one report word and hold it until taken
  task automatic send_report(input in_word_t w);
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (full);
    reports_sent++;
  endtask

  // One register write; the caller drops valid after the last one
  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_writes++;
  endtask

  // Stop offering and wait until every expected word has been popped
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  function automatic in_word_t report(input logic conn, input logic pres, input logic mov,
                                      input int md, input logic sta, input int sd,
                                      input logic [31:0] now, input int temp,
                                      input logic run, input int spd);
    in_word_t w;
    w.sensor_connected    = conn;
    w.presence_flag       = pres;
    w.moving_flag         = mov;
    w.moving_distance     = 10'(md);
    w.stationary_flag     = sta;
    w.stationary_distance = 10'(sd);
    w.now_ms              = now;
    w.temperature_tenths  = 12'(temp);
    w.fan_is_running      = run;
    w.fan_speed_now       = 8'(spd);
    return w;
  endfunction

  // Random report for one kind of episode; time moves forward, but noise may jump it
  function automatic in_word_t radar_report(input episode_e kind);
    in_word_t w;
    int       lo;
    int       pick;
    int       temp;
    w = '0;
    w.moving_distance     = 10'($urandom);
    w.stationary_distance = 10'($urandom);
    clock_ms = clock_ms + 32'($urandom_range(step_max));
    // mostly near the threshold so the fan decision flips often
    temp = cur_thr + $urandom_range(200) - 60;
    if ($urandom_range(4) == 0) temp = $urandom_range(1650) - 400;
    if (temp > 1250) temp = 1250;
    if (temp < -400) temp = -400;
    if ($urandom_range(6) == 0) fan_on = ~fan_on;
    w.fan_is_running   = fan_on;
    w.fan_speed_now    = ($urandom_range(2) == 0) ? 8'($urandom)
                                                  : 8'(cur_smin + $urandom_range(20));
    w.sensor_connected = ($urandom_range(40) != 0);
    case (kind)
      EP_PRESENT: begin
        w.presence_flag = 1'b1;
        pick = $urandom_range(19);
        w.moving_flag     = (pick >= 1 && pick <= 8) || pick >= 15;
        w.stationary_flag = pick >= 9;
        lo = (cur_min_dist < 1023) ? cur_min_dist + 1 : 1023;
        if ($urandom_range(7) != 0) begin
          w.moving_distance     = 10'($urandom_range(1023, lo));
          w.stationary_distance = 10'($urandom_range(1023, lo));
        end
      end
      EP_ABSENT: begin
        // now and then a presence flag with no target behind it
        w.presence_flag = ($urandom_range(9) == 0);
        if (!w.presence_flag) begin
          w.moving_flag     = 1'($urandom);
          w.stationary_flag = 1'($urandom);
        end
        if ($urandom_range(19) == 0) clock_ms = clock_ms + 32'($urandom_range(70000));
      end
      default: begin
        {w.sensor_connected, w.presence_flag, w.moving_flag, w.stationary_flag,
         w.fan_is_running} = 5'($urandom);
        if ($urandom_range(9) == 0) clock_ms = $urandom;
        temp = $urandom_range(4095) - 2048;
      end
    endcase
    w.now_ms             = clock_ms;
    w.temperature_tenths = 12'(temp);
    return w;
  endfunction

  // New settings for one phase: lowest, highest, then random subsets
  task automatic load_settings(input int phase);
    logic en;
    logic every;
    int   thr;
    int   smin;
    int   smax;
    int   dly;
    int   mind;
    int   hon;
    int   hoff;
    every = (phase < 2);
    case (phase)
      0: begin
        en = 1'b1; thr = -400; smin = 0; smax = 0;
        dly = 0; mind = 0; hon = 0; hoff = 0;
      end
      1: begin
        en = 1'b1; thr = 1250; smin = 255; smax = 255;
        dly = 65535; mind = 1023; hon = 65535; hoff = 65535;
      end
      default: begin
        en   = ($urandom_range(3) != 0);
        thr  = $urandom_range(1650) - 400;
        smin = $urandom_range(255);
        smax = $urandom_range(255);
        dly  = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(6);
        mind = ($urandom_range(5) == 0) ? $urandom_range(1023) : $urandom_range(150);
        hon  = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(2500);
        hoff = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(2500);
      end
    endcase
    // unused upper data bits carry noise
    cfg_write(CFG_AUTO_ENABLE, {15'($urandom), en});
    if (every || $urandom_range(3) != 0) begin
      cfg_write(CFG_TEMP_ON_TENTHS, {4'($urandom), 12'(thr)});
      cur_thr = thr;
    end
    if (every || $urandom_range(3) != 0) begin
      cfg_write(CFG_SPEED_MIN, {8'($urandom), 8'(smin)});
      cur_smin = smin;
    end
    if (every || $urandom_range(3) != 0) cfg_write(CFG_SPEED_MAX, {8'($urandom), 8'(smax)});
    if (every || $urandom_range(3) != 0) cfg_write(CFG_ABSENCE_DELAY_S, 16'(dly));
    if (every || $urandom_range(3) != 0) begin
      cfg_write(CFG_MIN_DISTANCE_CM, {6'($urandom), 10'(mind)});
      cur_min_dist = mind;
    end
    if (every || $urandom_range(3) != 0) cfg_write(CFG_PRESENCE_HOLD_MS, 16'(hon));
    if (every || $urandom_range(3) != 0) cfg_write(CFG_ABSENCE_HOLD_MS, 16'(hoff));
    cfg_valid <= 1'b0;
    case ($urandom_range(2))
      0:       step_max = 20;
      1:       step_max = 200;
      default: step_max = 1500;
    endcase
    // some phases run across the timestamp wrap
    if ($urandom_range(3) == 0) clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(20000));
  endtask

  // Result side: stall pattern changes every segment, long hold-off on request
  initial begin : drain_side
    int pct;
    int seg;
    pct = 100;
    seg = 0;
    forever begin
      if (seg == 0) begin
        seg = $urandom_range(20, 200);
        case ($urandom_range(4))
          0:       pct = 100;
          1:       pct = 90;
          2:       pct = 60;
          3:       pct = 30;
          default: pct = 5;
        endcase
      end
      seg--;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(99) < pct);
        @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int       r;
    int       gap;
    int       burst_left;
    int       len;
    int       sent;
    episode_e kind;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default settings with the automatic mode on
    cfg_write(CFG_AUTO_ENABLE, 16'd1);
    cfg_valid <= 1'b0;
    // link down with every field at its top value
    send_report(report(0, 1, 1, 1023, 1, 1023, 32'hFFFF_FFFF, 1250, 1, 255));
    // presence without a target flag
    send_report(report(1, 1, 0, 500, 0, 500, 0, 300, 0, 0));
    send_report(report(1, 1, 1, 21, 0, 0, 10, 300, 0, 0));
    // stationary target at the minimum distance is not valid
    send_report(report(1, 1, 0, 0, 1, 20, 20, 300, 0, 0));
    send_report(report(1, 1, 1, 1023, 0, 0, 100, 300, 0, 0));
    send_report(report(1, 1, 1, 500, 0, 0, 1099, 300, 0, 0));
    // both targets, moving wins; presence confirmed, start and full speed
    send_report(report(1, 1, 1, 300, 1, 5, 1100, 1250, 0, 0));
    send_report(report(1, 1, 1, 300, 0, 0, 1200, 251, 1, 30));
    send_report(report(1, 1, 1, 300, 0, 0, 1300, 250, 1, 30));
    send_report(report(1, 1, 1, 300, 0, 0, 1400, -400, 0, 0));
    send_report(report(1, 0, 0, 0, 0, 0, 2000, 300, 1, 0));
    send_report(report(1, 0, 0, 0, 0, 0, 9000, 300, 1, 0));
    send_report(report(0, 0, 0, 0, 0, 0, 10000, 300, 1, 0));
    // long absence with the fan already off, then running
    send_report(report(1, 0, 0, 0, 0, 0, 40000, 300, 0, 0));
    send_report(report(1, 0, 0, 0, 0, 0, 40001, 300, 1, 0));
    // presence hold across the timestamp wrap
    send_report(report(1, 1, 1, 700, 0, 0, 32'hFFFF_FF00, 400, 1, 100));
    send_report(report(1, 1, 1, 700, 0, 0, 32'h0000_02F0, 400, 1, 100));
    wait_drained();
    // minimum above maximum
    cfg_write(CFG_SPEED_MIN, 16'd200);
    cfg_write(CFG_SPEED_MAX, 16'd50);
    cfg_write(CFG_PRESENCE_HOLD_MS, 16'd0);
    cfg_valid <= 1'b0;
    send_report(report(1, 1, 1, 700, 0, 0, 32'h400, 1250, 1, 0));
    send_report(report(1, 1, 1, 700, 0, 0, 32'h410, 1250, 1, 50));
    wait_drained();
    // manual mode, then absence hold clears presence
    cfg_write(CFG_AUTO_ENABLE, 16'd0);
    cfg_valid <= 1'b0;
    send_report(report(1, 1, 1, 700, 0, 0, 32'h420, 1250, 0, 0));
    send_report(report(1, 0, 0, 0, 0, 0, 32'h500, 1250, 0, 0));
    send_report(report(1, 0, 0, 0, 0, 0, 32'h500 + 2000, 1250, 0, 0));

    // Random phases
    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      load_settings(p);
      if (p == 4) begin
        // result side holds off while reports keep coming
        hold_off_req = 1'b1;
        repeat (40) send_report(radar_report(EP_PRESENT));
      end
      sent = 0;
      while (sent < PHASE_REPORTS) begin
        r = $urandom_range(99);
        if (r < 55) begin
          kind = EP_PRESENT;
        end else if (r < 85) begin
          kind = EP_ABSENT;
        end else begin
          kind = EP_NOISE;
        end
        len = $urandom_range(1, 12);
        repeat (len) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (p % 3 == 0) ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
              push <= 1'b0;
              repeat (gap) @(posedge clk_i);
            end
          end
          send_report(radar_report(kind));
          burst_left--;
          sent++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Coverage: %0d reports, %0d words checked, %0d register writes over %0d phases",
             reports_sent, checked, cfg_writes, PHASES);
    $display("Coverage: %0d presence changes, %0d fan start or stop commands",
             presence_edges, fan_cmds);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
